[rtl/servo_ramp_limiter_core_assert.svh]
// Assertion macros for the ramp limiter; only srl_ramp includes them.
// Each macro checks on the rising edge of clock and is held off while reset is high.
`ifndef SERVO_RAMP_LIMITER_CORE_ASSERT_SVH
`define SERVO_RAMP_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SRL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("servo ramp limiter check failed");

// Next-cycle implication.
`define SRL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("servo ramp limiter check failed");

`endif

[rtl/srl_pkg.sv]
package srl_pkg;

   localparam int POSITION_BITS_DEFAULT = 12;
   localparam int CHANNEL_BITS = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int ACTION_BITS = 2;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_TICK       = 2'd0,
      ACT_SET_TARGET = 2'd1,
      ACT_SET_POS    = 2'd2,
      ACT_SET_STEP   = 2'd3
   } action_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL   = 2'd2;

endpackage

[rtl/servo_ramp_limiter_core.sv]
// Channel  Handshake            Payload
// req      req_valid/req_stall  req_action, req_value, req_step_value
// rsp      rsp_valid/rsp_stall  rsp_position, rsp_pwm_write, rsp_pwm_channel,
//                               rsp_reached, rsp_reached_step
// csr      csr_valid/csr_ready  csr_index, csr_data
//
// One item per cycle sustained while rsp_stall is low; a req beat passes the input
// register, then the ramp step into the result register, before its rsp beat.
// Reset is synchronous: limits go to full range, channel 0, position, target
// and step to zero (frozen).
// rsp_stall holds the result register; the input register then holds one
// more beat before req_stall rises. csr writes are taken every cycle.
module servo_ramp_limiter_core #(
   parameter int POSITION_BITS = srl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [srl_pkg::ACTION_BITS-1:0]   req_action,
   input  logic [POSITION_BITS-1:0]          req_value,
   input  logic signed [POSITION_BITS:0]     req_step_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [POSITION_BITS-1:0]          rsp_position,
   output logic                              rsp_pwm_write,
   output logic [srl_pkg::CHANNEL_BITS-1:0]  rsp_pwm_channel,
   output logic                              rsp_reached,
   output logic signed [POSITION_BITS:0]     rsp_reached_step,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [POSITION_BITS-1:0]          csr_data
);

   logic                             stage_valid_ff, stage_valid_in;
   srl_pkg::action_type              action_ff;
   logic [POSITION_BITS-1:0]         value_ff;
   logic signed [POSITION_BITS:0]    step_ff;
   logic                             take;
   logic                             req_beat;
   logic [POSITION_BITS-1:0]         min_limit, max_limit;
   logic [srl_pkg::CHANNEL_BITS-1:0] channel;

   assign req_stall = stage_valid_ff && !take;
   assign req_beat  = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_beat) begin
         stage_valid_in = 1'b1;
      end else if (take) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         action_ff <= srl_pkg::action_type'(req_action);
         value_ff  <= req_value;
         step_ff   <= req_step_value;
      end
   end

   srl_csr #(.POSITION_BITS(POSITION_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .min_limit (min_limit),
      .max_limit (max_limit),
      .channel   (channel)
   );

   srl_ramp #(.POSITION_BITS(POSITION_BITS)) u_ramp (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (stage_valid_ff),
      .in_take          (take),
      .in_action        (action_ff),
      .in_value         (value_ff),
      .in_step          (step_ff),
      .min_limit        (min_limit),
      .max_limit        (max_limit),
      .channel          (channel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_pwm_write    (rsp_pwm_write),
      .rsp_pwm_channel  (rsp_pwm_channel),
      .rsp_reached      (rsp_reached),
      .rsp_reached_step (rsp_reached_step)
   );

endmodule

[rtl/srl_csr.sv]
module srl_csr #(
   parameter int POSITION_BITS = srl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [POSITION_BITS-1:0]          csr_data,
   output logic [POSITION_BITS-1:0]          min_limit,
   output logic [POSITION_BITS-1:0]          max_limit,
   output logic [srl_pkg::CHANNEL_BITS-1:0]  channel
);

   logic [POSITION_BITS-1:0]         min_limit_ff, min_limit_in;
   logic [POSITION_BITS-1:0]         max_limit_ff, max_limit_in;
   logic [srl_pkg::CHANNEL_BITS-1:0] channel_ff, channel_in;

   assign csr_ready = 1'b1;

   always_comb begin
      min_limit_in = min_limit_ff;
      max_limit_in = max_limit_ff;
      channel_in   = channel_ff;
      if (csr_valid) begin
         case (csr_index)
            srl_pkg::REG_MIN_LIMIT: min_limit_in = csr_data;
            srl_pkg::REG_MAX_LIMIT: max_limit_in = csr_data;
            srl_pkg::REG_CHANNEL:   channel_in   = csr_data[srl_pkg::CHANNEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_limit_ff <= '0;
         max_limit_ff <= '1;
         channel_ff   <= '0;
      end else begin
         min_limit_ff <= min_limit_in;
         max_limit_ff <= max_limit_in;
         channel_ff   <= channel_in;
      end
   end

   assign min_limit = min_limit_ff;
   assign max_limit = max_limit_ff;
   assign channel   = channel_ff;

endmodule

[rtl/srl_ramp.sv]
`include "servo_ramp_limiter_core_assert.svh"

module srl_ramp #(
   parameter int POSITION_BITS = srl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_take,
   input  srl_pkg::action_type               in_action,
   input  logic [POSITION_BITS-1:0]          in_value,
   input  logic signed [POSITION_BITS:0]     in_step,
   input  logic [POSITION_BITS-1:0]          min_limit,
   input  logic [POSITION_BITS-1:0]          max_limit,
   input  logic [srl_pkg::CHANNEL_BITS-1:0]  channel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [POSITION_BITS-1:0]          rsp_position,
   output logic                              rsp_pwm_write,
   output logic [srl_pkg::CHANNEL_BITS-1:0]  rsp_pwm_channel,
   output logic                              rsp_reached,
   output logic signed [POSITION_BITS:0]     rsp_reached_step
);

   localparam int SumBits = POSITION_BITS + 2;

   logic [POSITION_BITS-1:0]         pos_ff, pos_in;
   logic [POSITION_BITS-1:0]         goal_ff, goal_in;
   logic signed [POSITION_BITS:0]    rate_ff, rate_in;

   logic                             out_valid_ff, out_valid_in;
   logic [POSITION_BITS-1:0]         out_pos_ff;
   logic                             out_write_ff, write_in;
   logic [srl_pkg::CHANNEL_BITS-1:0] out_chan_ff;
   logic                             out_reached_ff, reached_in;
   logic signed [POSITION_BITS:0]    out_rstep_ff, rstep_in;

   logic [POSITION_BITS-1:0]         upper_cut, clamped;
   logic signed [SumBits-1:0]        pos_ext, goal_ext, rate_ext, sum;
   logic [POSITION_BITS-1:0]         up_next, down_next;

   assign in_take = in_valid && (!out_valid_ff || !rsp_stall);

   // Lower to max first, then raise to min.
   assign upper_cut = (in_value > max_limit) ? max_limit : in_value;
   assign clamped   = (upper_cut < min_limit) ? min_limit : upper_cut;

   assign pos_ext  = signed'({2'b00, pos_ff});
   assign goal_ext = signed'({2'b00, goal_ff});
   assign rate_ext = SumBits'(rate_ff);
   assign sum      = pos_ext + rate_ext;

   // Stop on the goal rather than pass it.
   assign up_next   = (sum > goal_ext) ? goal_ff : sum[POSITION_BITS-1:0];
   assign down_next = (sum < goal_ext) ? goal_ff : sum[POSITION_BITS-1:0];

   always_comb begin
      pos_in     = pos_ff;
      goal_in    = goal_ff;
      rate_in    = rate_ff;
      write_in   = 1'b0;
      reached_in = 1'b0;
      rstep_in   = '0;
      case (in_action)
         srl_pkg::ACT_TICK: begin
            if (rate_ff > 0) begin
               if (pos_ff < goal_ff && pos_ff < max_limit) begin
                  pos_in   = up_next;
                  write_in = 1'b1;
               end else begin
                  reached_in = 1'b1;
                  rstep_in   = rate_ff;
                  rate_in    = '0;
               end
            end else if (rate_ff < 0) begin
               if (pos_ff > goal_ff && pos_ff > min_limit) begin
                  pos_in   = down_next;
                  write_in = 1'b1;
               end else begin
                  reached_in = 1'b1;
                  rstep_in   = rate_ff;
                  rate_in    = '0;
               end
            end
         end
         srl_pkg::ACT_SET_TARGET: goal_in = clamped;
         srl_pkg::ACT_SET_POS: begin
            pos_in  = clamped;
            goal_in = clamped;
            rate_in = '0;
         end
         srl_pkg::ACT_SET_STEP: rate_in = in_step;
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_take) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         goal_ff      <= '0;
         rate_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (in_take) begin
            pos_ff  <= pos_in;
            goal_ff <= goal_in;
            rate_ff <= rate_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         out_pos_ff     <= pos_in;
         out_write_ff   <= write_in;
         out_chan_ff    <= channel;
         out_reached_ff <= reached_in;
         out_rstep_ff   <= rstep_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_position     = out_pos_ff;
   assign rsp_pwm_write    = out_write_ff;
   assign rsp_pwm_channel  = out_chan_ff;
   assign rsp_reached      = out_reached_ff;
   assign rsp_reached_step = out_rstep_ff;

   `SRL_ASSERT_NOW(a_write_or_reached, out_valid_ff, !(out_write_ff && out_reached_ff))
   `SRL_ASSERT_NOW(a_out_tracks_state, out_valid_ff, out_pos_ff == pos_ff)
   `SRL_ASSERT_NEXT(a_reached_freezes, in_take && reached_in, rate_ff == 0)
   `SRL_ASSERT_NEXT(a_setpos_aligns, in_take && in_action == srl_pkg::ACT_SET_POS,
                    goal_ff == pos_ff && rate_ff == 0)

endmodule
